FILE: sv/usr_pkg.sv
`default_nettype none

package usr_pkg;

	localparam int CFG_BITS      = 20;
	localparam int THR_BITS      = 15;
	localparam int DIST_BITS     = 16;
	localparam int PULSE_BITS    = 4;
	localparam int CFG_IDX_BITS  = 2;
	localparam int DIST_MUL_BITS = 15;

	localparam int TRIG_LOW_TICKS = 2;
	localparam int DIST_MUL       = 17983;
	localparam int DIST_MAX       = 17983;

	localparam logic signed [DIST_BITS-1:0] DIST_TIMEOUT = -16'sd16;

	localparam logic [CFG_BITS-1:0] INTERVAL_RST  = 20'd60000;
	localparam logic [CFG_BITS-1:0] TIMEOUT_RST   = 20'd30000;
	localparam logic [THR_BITS-1:0] THRESHOLD_RST = 15'd320;

	localparam int TRIG_HIGH_TICKS_DEF = 10;
	localparam int WIDTH_BITS_DEF      = 16;
	localparam int ELAPSED_BITS_DEF    = 20;

	localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG_LOW,
		PH_TRIG_HIGH,
		PH_WAIT
	} phase_t;

endpackage

`default_nettype wire

FILE: sv/usr_dist.sv
`default_nettype none

module usr_dist #(
	parameter int WIDTH_BITS = usr_pkg::WIDTH_BITS_DEF
) (
	input  wire logic [WIDTH_BITS-1:0]        echo_width,
	output logic      [usr_pkg::THR_BITS-1:0] dist_q4
);
	import usr_pkg::*;

	localparam int PROD_BITS = WIDTH_BITS + DIST_MUL_BITS;

	logic [PROD_BITS-1:0] prod_w;
	logic [31:0]          quot_w;

	// width * 17983 / 65536, clipped to the sensor range
	always_comb begin
		prod_w = PROD_BITS'(echo_width) * PROD_BITS'(DIST_MUL);
		quot_w = 32'(prod_w >> 16);
		if (quot_w > 32'(DIST_MAX)) begin
			dist_q4 = THR_BITS'(DIST_MAX);
		end else begin
			dist_q4 = quot_w[THR_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: sv/ultrasonic_ranger_controller.sv
// Ultrasonic ranger controller, one input request per microsecond tick.
// Input channel (in_valid/in_ready) carries the sampled echo level; every
// accepted request yields exactly one output request (out_valid/out_ready)
// with the trigger level to drive, a new-measurement strobe, the timeout
// flag, the last distance in 1/16 cm (-16 on timeout) and the near flag.
// While idle the block waits interval_us ticks from the last trigger start,
// then drives trigger low 2 ticks and high TRIG_HIGH_TICKS ticks, measures
// the echo high width and converts it to distance; timeout_us bounds the
// wait after the trigger start.
// Latency: the output request is valid the cycle after the input is taken.
// Throughput: one request per cycle while out_ready is high; the state update and the distance
// multiply fit in the single stage between the tick and the output register.
// in_ready is high while the output register is empty or being drained, so
// a stalled receiver stalls the input after one request is held.
// Reset: idle phase, counters cleared, last distance -16 with timeout set,
// registers at interval 60000, timeout 30000, threshold 320.
// cfg_* writes are taken at once and are meant for idle periods.
`default_nettype none

module ultrasonic_ranger_controller #(
	parameter int TRIG_HIGH_TICKS = usr_pkg::TRIG_HIGH_TICKS_DEF,
	parameter int WIDTH_BITS      = usr_pkg::WIDTH_BITS_DEF,
	parameter int ELAPSED_BITS    = usr_pkg::ELAPSED_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [usr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [usr_pkg::CFG_BITS-1:0]         cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 echo_level,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      trig_level,
	output logic                                      new_measurement,
	output logic                                      timed_out,
	output logic signed [usr_pkg::DIST_BITS-1:0]      distance_q4,
	output logic                                      object_near
);
	import usr_pkg::*;

	localparam int CMP_BITS = (ELAPSED_BITS > CFG_BITS) ? ELAPSED_BITS : CFG_BITS;

	logic [CFG_BITS-1:0] interval_q;
	logic [CFG_BITS-1:0] timeout_q;
	logic [THR_BITS-1:0] threshold_q;

	phase_t                    phase_q, phase_nxt;
	logic [ELAPSED_BITS-1:0]   since_q, since_nxt;
	logic [PULSE_BITS-1:0]     pulse_q, pulse_nxt, pulse_inc;
	logic                      echo_act_q, echo_act_nxt;
	logic [WIDTH_BITS-1:0]     width_q, width_nxt;
	logic signed [DIST_BITS-1:0] dist_q, dist_nxt;
	logic                      tout_q, tout_nxt;

	logic                      trig_nxt, fresh_nxt, near_nxt, done_w;
	logic [THR_BITS-1:0]       conv_dist;

	logic                      out_valid_q;
	logic                      trig_q, fresh_q, tout_out_q, near_q;
	logic signed [DIST_BITS-1:0] dist_out_q;

	logic                      accept;

	usr_dist #(
		.WIDTH_BITS (WIDTH_BITS)
	) u_dist (
		.echo_width (width_q),
		.dist_q4    (conv_dist)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= INTERVAL_RST;
			timeout_q   <= TIMEOUT_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL:  interval_q  <= cfg_data;
				REG_TIMEOUT:   timeout_q   <= cfg_data;
				REG_THRESHOLD: threshold_q <= cfg_data[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_nxt    = phase_q;
		since_nxt    = since_q;
		pulse_nxt    = pulse_q;
		echo_act_nxt = echo_act_q;
		width_nxt    = width_q;
		dist_nxt     = dist_q;
		tout_nxt     = tout_q;
		trig_nxt     = 1'b0;
		fresh_nxt    = 1'b0;
		done_w       = 1'b0;
		pulse_inc    = pulse_q + PULSE_BITS'(1);

		if (phase_q == PH_IDLE) begin
			if (CMP_BITS'(since_q) >= CMP_BITS'(interval_q) || since_q == '1) begin
				since_nxt    = '0;
				phase_nxt    = PH_TRIG_LOW;
				pulse_nxt    = '0;
				echo_act_nxt = 1'b0;
				width_nxt    = '0;
			end else begin
				since_nxt = since_q + ELAPSED_BITS'(1);
			end
		end else begin
			if (since_q != '1) begin
				since_nxt = since_q + ELAPSED_BITS'(1);
			end
			case (phase_q)
				PH_TRIG_LOW: begin
					pulse_nxt = pulse_inc;
					if (pulse_inc >= PULSE_BITS'(TRIG_LOW_TICKS)) begin
						pulse_nxt = '0;
						phase_nxt = PH_TRIG_HIGH;
					end
				end
				PH_TRIG_HIGH: begin
					trig_nxt  = 1'b1;
					pulse_nxt = pulse_inc;
					if (pulse_inc >= PULSE_BITS'(TRIG_HIGH_TICKS)) begin
						pulse_nxt = '0;
						phase_nxt = PH_WAIT;
					end
				end
				default: begin
					if (!echo_act_q && echo_level) begin
						echo_act_nxt = 1'b1;
						width_nxt    = WIDTH_BITS'(1);
					end else if (echo_act_q && echo_level) begin
						if (width_q != '1) begin
							width_nxt = width_q + WIDTH_BITS'(1);
						end
					end else if (echo_act_q && !echo_level) begin
						dist_nxt  = DIST_BITS'(conv_dist);
						tout_nxt  = 1'b0;
						fresh_nxt = 1'b1;
						done_w    = 1'b1;
					end
					// falling edge takes priority over timeout
					if (!done_w && (CMP_BITS'(since_nxt) > CMP_BITS'(timeout_q)
						|| since_nxt == '1)) begin
						dist_nxt  = DIST_TIMEOUT;
						tout_nxt  = 1'b1;
						fresh_nxt = 1'b1;
						done_w    = 1'b1;
					end
					if (done_w) begin
						phase_nxt    = PH_IDLE;
						echo_act_nxt = 1'b0;
					end
				end
			endcase
		end

		near_nxt = !dist_nxt[DIST_BITS-1] && (dist_nxt[THR_BITS-1:0] < threshold_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			since_q    <= '0;
			pulse_q    <= '0;
			echo_act_q <= 1'b0;
			width_q    <= '0;
			dist_q     <= DIST_TIMEOUT;
			tout_q     <= 1'b1;
		end else if (accept) begin
			phase_q    <= phase_nxt;
			since_q    <= since_nxt;
			pulse_q    <= pulse_nxt;
			echo_act_q <= echo_act_nxt;
			width_q    <= width_nxt;
			dist_q     <= dist_nxt;
			tout_q     <= tout_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trig_q     <= trig_nxt;
			fresh_q    <= fresh_nxt;
			tout_out_q <= tout_nxt;
			dist_out_q <= dist_nxt;
			near_q     <= near_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign trig_level      = trig_q;
	assign new_measurement = fresh_q;
	assign timed_out       = tout_out_q;
	assign distance_q4     = dist_out_q;
	assign object_near     = near_q;

	a_tout_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> distance_q4 == DIST_TIMEOUT)
		else $error("timeout flag without timeout distance");

	a_dist_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !timed_out |-> !distance_q4[DIST_BITS-1])
		else $error("negative distance on a completed echo");

	a_near_tout: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && object_near |-> !timed_out)
		else $error("object near while timed out");

	a_trig_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trig_level |-> !new_measurement)
		else $error("measurement completed during trigger pulse");

	a_echo_wait: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_WAIT |-> !echo_act_q)
		else $error("echo tracked outside wait phase");

	a_pulse_rng: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TRIG_HIGH |-> pulse_q < PULSE_BITS'(TRIG_HIGH_TICKS))
		else $error("trigger pulse counter overran");

endmodule

`default_nettype wire

FILE: tb/ranger_scoreboard_pkg.sv
package ranger_tb_pkg;

	import usr_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0]   REG_UNUSED  = 2'd3;
	localparam logic [CFG_BITS-1:0]       ELAPSED_SAT = '1;
	localparam logic [WIDTH_BITS_DEF-1:0] WIDTH_SAT   = '1;

	typedef struct packed {
		logic                        trig;
		logic                        fresh;
		logic                        tout;
		logic signed [DIST_BITS-1:0] dist_q4;
		logic                        near;
	} ranger_report_t;

	class ranger_scoreboard;
		logic [CFG_BITS-1:0]         interval_us;
		logic [CFG_BITS-1:0]         timeout_us;
		logic [THR_BITS-1:0]         threshold_q4;
		phase_t                      phase;
		logic [CFG_BITS-1:0]         since_trig;
		logic [PULSE_BITS-1:0]       pulse_cnt;
		logic                        echo_on;
		logic [WIDTH_BITS_DEF-1:0]   echo_w;
		logic signed [DIST_BITS-1:0] last_dist;
		logic                        last_tout;
		ranger_report_t              expected_reports[$];
		int                          errors;

		function new();
			interval_us  = INTERVAL_RST;
			timeout_us   = TIMEOUT_RST;
			threshold_q4 = THRESHOLD_RST;
			phase        = PH_IDLE;
			since_trig   = '0;
			pulse_cnt    = '0;
			echo_on      = 1'b0;
			echo_w       = '0;
			last_dist    = DIST_TIMEOUT;
			last_tout    = 1'b1;
			errors       = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
			case (idx)
				REG_INTERVAL:  interval_us  = data;
				REG_TIMEOUT:   timeout_us   = data;
				REG_THRESHOLD: threshold_q4 = data[THR_BITS-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		// one tick request in, one expected report out
		function void take_tick(logic echo);
			ranger_report_t r;
			logic           done;
			int unsigned    prod;
			r    = '0;
			done = 1'b0;
			if (phase == PH_IDLE) begin
				if (since_trig >= interval_us || since_trig == ELAPSED_SAT) begin
					since_trig = '0;
					phase      = PH_TRIG_LOW;
					pulse_cnt  = '0;
					echo_on    = 1'b0;
					echo_w     = '0;
				end else begin
					since_trig++;
				end
			end else begin
				if (since_trig != ELAPSED_SAT)
					since_trig++;
				case (phase)
					PH_TRIG_LOW: begin
						pulse_cnt++;
						if (pulse_cnt >= TRIG_LOW_TICKS) begin
							pulse_cnt = '0;
							phase     = PH_TRIG_HIGH;
						end
					end
					PH_TRIG_HIGH: begin
						r.trig = 1'b1;
						pulse_cnt++;
						if (pulse_cnt >= TRIG_HIGH_TICKS_DEF) begin
							pulse_cnt = '0;
							phase     = PH_WAIT;
						end
					end
					default: begin
						if (!echo_on && echo) begin
							echo_on = 1'b1;
							echo_w  = WIDTH_BITS_DEF'(1);
						end else if (echo_on && echo) begin
							if (echo_w != WIDTH_SAT)
								echo_w++;
						end else if (echo_on && !echo) begin
							prod = 32'(echo_w);
							prod = (prod * DIST_MUL) >> 16;
							if (prod > DIST_MAX)
								prod = DIST_MAX;
							last_dist = prod[DIST_BITS-1:0];
							last_tout = 1'b0;
							r.fresh   = 1'b1;
							done      = 1'b1;
						end
						// falling edge takes priority over timeout
						if (!done && (since_trig > timeout_us || since_trig == ELAPSED_SAT)) begin
							last_dist = DIST_TIMEOUT;
							last_tout = 1'b1;
							r.fresh   = 1'b1;
							done      = 1'b1;
						end
						if (done) begin
							phase   = PH_IDLE;
							echo_on = 1'b0;
						end
					end
				endcase
			end
			r.tout    = last_tout;
			r.dist_q4 = last_dist;
			r.near    = !last_dist[DIST_BITS-1] && (last_dist < $signed({1'b0, threshold_q4}));
			expected_reports.push_back(r);
		endfunction

		function void check_report(ranger_report_t got);
			ranger_report_t want;
			if (expected_reports.size() == 0) begin
				$error("output request with nothing expected");
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			if (got.trig !== want.trig) begin
				$error("trig_level expected %0d actual %0d", want.trig, got.trig);
				errors++;
			end
			if (got.fresh !== want.fresh) begin
				$error("new_measurement expected %0d actual %0d", want.fresh, got.fresh);
				errors++;
			end
			if (got.tout !== want.tout) begin
				$error("timed_out expected %0d actual %0d", want.tout, got.tout);
				errors++;
			end
			if (got.dist_q4 !== want.dist_q4) begin
				$error("distance_q4 expected %0d actual %0d", want.dist_q4, got.dist_q4);
				errors++;
			end
			if (got.near !== want.near) begin
				$error("object_near expected %0d actual %0d", want.near, got.near);
				errors++;
			end
		endfunction
	endclass

endpackage

FILE: tb/ultrasonic_ranger_controller_tb.sv
module ultrasonic_ranger_controller_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import usr_pkg::*;
	import ranger_tb_pkg::*;

	localparam int RUN_LIMIT_NS = 2_000_000;

	logic                        clk             = 1'b0;
	logic                        arst_n          = 1'b0;
	logic                        cfg_we          = 1'b0;
	logic [CFG_IDX_BITS-1:0]     cfg_index       = '0;
	logic [CFG_BITS-1:0]         cfg_data        = '0;
	logic                        in_valid        = 1'b0;
	logic                        in_ready;
	logic                        echo_level      = 1'b0;
	logic                        out_valid;
	logic                        out_ready       = 1'b0;
	logic                        trig_level;
	logic                        new_measurement;
	logic                        timed_out;
	logic signed [DIST_BITS-1:0] distance_q4;
	logic                        object_near;

	int src_idle_pct;
	int snk_idle_pct;
	int snk_hold;

	ranger_scoreboard sb = new();

	ultrasonic_ranger_controller i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.echo_level      (echo_level),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.trig_level      (trig_level),
		.new_measurement (new_measurement),
		.timed_out       (timed_out),
		.distance_q4     (distance_q4),
		.object_near     (object_near)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("ultrasonic_ranger_controller verification failed");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_report(ranger_report_t'{trig_level, new_measurement, timed_out,
					distance_q4, object_near});
			if (snk_hold > 0) begin
				snk_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	task automatic send_tick(input logic e);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		echo_level <= e;
		do @(posedge clk); while (!in_ready);
		sb.take_tick(e);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_BITS-1:0] interval, input logic [CFG_BITS-1:0] tmo,
			input logic [CFG_BITS-1:0] thr);
		write_reg(REG_INTERVAL, interval);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_THRESHOLD, thr);
	endtask

	task automatic wait_for_echo_window(input logic e);
		while (sb.phase != PH_WAIT)
			send_tick(e);
	endtask

	// echo as pulses of random width and spacing, with some single-tick noise
	task automatic run_random(input int n);
		int   seg;
		logic lvl;
		seg = 0;
		lvl = 1'b1;
		repeat (n) begin
			if (seg <= 0) begin
				lvl = !lvl;
				if (lvl)
					seg = $urandom_range(40, 1);
				else if ($urandom_range(7) == 0)
					seg = $urandom_range(150, 40);
				else
					seg = $urandom_range(30, 1);
			end
			if ($urandom_range(19) == 0)
				send_tick(1'($urandom_range(1)));
			else
				send_tick(lvl);
			seg--;
		end
	endtask

	initial begin
		src_idle_pct = 11;
		snk_idle_pct = 58;
		snk_hold     = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle counting only
		run_random(30);
		drain();

		configure(20'd4, 20'd40, 20'd5);
		wait_for_echo_window(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_for_echo_window(1'b0);
		while (sb.phase == PH_WAIT)
			send_tick(1'b0);
		// falling edge on the timeout tick
		wait_for_echo_window(1'b0);
		while (sb.since_trig < sb.timeout_us)
			send_tick(1'b1);
		send_tick(1'b0);
		// rising edge on the timeout tick
		wait_for_echo_window(1'b0);
		while (sb.since_trig < sb.timeout_us)
			send_tick(1'b0);
		send_tick(1'b1);
		drain();

		// long echo, back-to-back triggers, unused register index
		configure(20'd0, 20'hFFFFF, 20'hFFFFF);
		write_reg(REG_UNUSED, 20'h5A5A5);
		wait_for_echo_window(1'b0);
		repeat (80) send_tick(1'b1);
		send_tick(1'b0);
		run_random(20);
		drain();

		configure(20'd1000000, 20'd1000000, 20'd0);
		run_random(20);
		drain();

		for (int p = 0; p < 5; p++) begin
			if (p == 2) begin
				src_idle_pct = 58;
				snk_idle_pct = 11;
			end else if (p == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			configure(CFG_BITS'($urandom_range(30)), CFG_BITS'($urandom_range(60, 10)),
				CFG_BITS'(($urandom_range(3) == 0) ? $urandom_range(DIST_MAX)
					: $urandom_range(12)));
			if (p == 0)
				snk_hold = 300;
			run_random(20);
			if (p == 3)
				drain();
			run_random(20);
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("ultrasonic_ranger_controller verification clean");
		else
			$display("ultrasonic_ranger_controller verification failed");
		$finish;
	end

endmodule
